### hw/rtl/i2a_pkg.sv
// Shared types, constants and the digit-to-character function for the ASCII converter.
`timescale 1ns / 1ps
`default_nettype none

package i2a_pkg;

  // Width of the converted word and the derived digit-register geometry.
  localparam int unsigned VALUE_BITS = 32;
  localparam int unsigned IN_BITS    = 32;
  // Decimal digits needed for 2^VALUE_BITS - 1 (1233 / 4096 approximates log10(2)).
  localparam int unsigned NDIG       = ((VALUE_BITS * 1233) >> 12) + 1;
  localparam int unsigned BCD_W      = NDIG * 4;
  localparam int unsigned CNT_W      = $clog2(VALUE_BITS + 1);
  localparam int unsigned REM_W      = $clog2(NDIG + 1);

  // ASCII codes.
  localparam logic [7:0] CHAR_ZERO       = 8'h30;
  localparam logic [7:0] CHAR_MINUS      = 8'h2D;
  localparam logic [7:0] CHAR_UPPER_BASE = 8'h37;  // 'A' - 10
  localparam logic [7:0] CHAR_LOWER_BASE = 8'h57;  // 'a' - 10

  // Output format selector.
  typedef enum logic [1:0] {
    OP_SDEC = 2'd0,
    OP_UDEC = 2'd1,
    OP_HEXL = 2'd2,
    OP_HEXU = 2'd3
  } op_e;

  // Top-level sequencer states.
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CONV,
    ST_EMIT
  } state_e;

  // Control word handed from the sequencer to the character emitter.
  typedef struct packed {
    logic load;
    logic neg;
    logic upper;
  } emit_ctrl_t;

  // Map one digit (0-15) to its ASCII character.
  function automatic logic [7:0] digit_char(input logic [3:0] d, input logic upper);
    logic [7:0] ext;
    ext = {4'h0, d};
    if (d < 4'd10) begin
      return CHAR_ZERO + ext;
    end else if (upper) begin
      return CHAR_UPPER_BASE + ext;
    end else begin
      return CHAR_LOWER_BASE + ext;
    end
  endfunction

endpackage

`default_nettype wire

### hw/rtl/i2a_bcd.sv
// Bit-serial binary to BCD converter (shift-and-add-3), with a direct nibble load for hex.
`timescale 1ns / 1ps
`default_nettype none

module i2a_bcd import i2a_pkg::*; (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  start_i,
  input  wire logic                  hex_i,
  input  wire logic [VALUE_BITS-1:0] mag_i,
  output logic                       done_o,
  output logic [BCD_W-1:0]           digits_o
);

  logic [VALUE_BITS-1:0] bin_q, bin_d;
  logic [BCD_W-1:0]      bcd_q, bcd_d;
  logic [BCD_W-1:0]      adj;
  logic [CNT_W-1:0]      cnt_q, cnt_d;
  logic                  busy_q, busy_d;
  logic                  done_q, done_d;

  // Add 3 to every BCD digit that is 5 or more before the next shift.
  always_comb begin
    for (int i = 0; i < NDIG; i++) begin
      adj[i*4 +: 4] = (bcd_q[i*4 +: 4] >= 4'd5) ? (bcd_q[i*4 +: 4] + 4'd3)
                                                : bcd_q[i*4 +: 4];
    end
  end

  // One binary bit enters the BCD register per cycle, most significant first.
  always_comb begin
    bin_d  = bin_q;
    bcd_d  = bcd_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    if (start_i) begin
      if (hex_i) begin
        bcd_d  = BCD_W'(mag_i);
        done_d = 1'b1;
      end else begin
        bin_d  = mag_i;
        bcd_d  = '0;
        cnt_d  = CNT_W'(VALUE_BITS);
        busy_d = 1'b1;
      end
    end else if (busy_q) begin
      bcd_d = {adj[BCD_W-2:0], bin_q[VALUE_BITS-1]};
      bin_d = {bin_q[VALUE_BITS-2:0], 1'b0};
      cnt_d = cnt_q - CNT_W'(1);
      if (cnt_q == CNT_W'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  // Data shift registers.
  always_ff @(posedge clk_i) begin
    bin_q <= bin_d;
    bcd_q <= bcd_d;
  end

  assign done_o   = done_q;
  assign digits_o = bcd_q;

endmodule

`default_nettype wire

### hw/rtl/i2a_emit.sv
// Character emitter: shifts digits out most significant first, drops leading zeros.
`timescale 1ns / 1ps
`default_nettype none

module i2a_emit import i2a_pkg::*; (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire emit_ctrl_t       ctrl_i,
  input  wire logic [BCD_W-1:0] digits_i,
  output logic                  active_o,
  output logic                  valid_o,
  output logic [7:0]            char_code_o,
  output logic                  last_o
);

  logic [BCD_W-1:0] dig_q, dig_d;
  logic [REM_W-1:0] rem_q, rem_d;
  logic             lead_q, lead_d;
  logic             neg_q, neg_d;
  logic             upper_q, upper_d;
  logic             active_q, active_d;
  logic             valid_q, valid_d;
  logic [7:0]       char_q, char_d;
  logic             last_q, last_d;
  logic [3:0]       top_dig;

  assign top_dig = dig_q[BCD_W-1 -: 4];

  // After any '-', one digit leaves dig_q per cycle; a leading zero is skipped
  // unless it is the final digit, so zero still prints as '0'.
  always_comb begin
    dig_d    = dig_q;
    rem_d    = rem_q;
    lead_d   = lead_q;
    neg_d    = neg_q;
    upper_d  = upper_q;
    active_d = active_q;
    valid_d  = 1'b0;
    char_d   = char_q;
    last_d   = last_q;
    if (ctrl_i.load) begin
      dig_d    = digits_i;
      rem_d    = REM_W'(NDIG);
      lead_d   = 1'b1;
      neg_d    = ctrl_i.neg;
      upper_d  = ctrl_i.upper;
      active_d = 1'b1;
    end else if (active_q) begin
      if (neg_q) begin
        valid_d = 1'b1;
        char_d  = CHAR_MINUS;
        last_d  = 1'b0;
        neg_d   = 1'b0;
      end else begin
        dig_d = {dig_q[BCD_W-5:0], 4'h0};
        rem_d = rem_q - REM_W'(1);
        if (!(lead_q && (top_dig == 4'h0) && (rem_q != REM_W'(1)))) begin
          valid_d = 1'b1;
          char_d  = digit_char(top_dig, upper_q);
          last_d  = (rem_q == REM_W'(1));
          lead_d  = 1'b0;
          if (rem_q == REM_W'(1)) begin
            active_d = 1'b0;
          end
        end
      end
    end
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rem_q    <= '0;
      lead_q   <= 1'b0;
      neg_q    <= 1'b0;
      upper_q  <= 1'b0;
      active_q <= 1'b0;
      valid_q  <= 1'b0;
    end else begin
      rem_q    <= rem_d;
      lead_q   <= lead_d;
      neg_q    <= neg_d;
      upper_q  <= upper_d;
      active_q <= active_d;
      valid_q  <= valid_d;
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    dig_q  <= dig_d;
    char_q <= char_d;
    last_q <= last_d;
  end

  assign active_o    = active_q;
  assign valid_o     = valid_q;
  assign char_code_o = char_q;
  assign last_o      = last_q;

endmodule

`default_nettype wire

### hw/rtl/integer_to_ascii_digits.sv
// Top level: converts one word to ASCII text, one character word per strobe.
// Decimal: the BCD converter shifts in all VALUE_BITS bits, the digits are handed to the
// emitter, which puts out '-' for a negative value and then visits each digit position
// in turn (leading zeros skipped without output). Hex loads the nibbles directly instead.
// A new start is taken only in idle; busy_o stays high until the last character is on
// the ports. Results cannot be stalled.
// Reset (rst_ni low, asynchronous) returns the block to idle with no output pending.
`timescale 1ns / 1ps
`default_nettype none

module integer_to_ascii_digits import i2a_pkg::*; (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               start_i,
  output logic                    busy_o,
  input  wire logic [IN_BITS-1:0] value_i,
  input  wire logic [1:0]         op_i,
  output logic                    valid_o,
  output logic [7:0]              char_code_o,
  output logic                    last_o
);

  state_e                state_q, state_d;
  op_e                   op;
  logic [VALUE_BITS-1:0] word;
  logic [VALUE_BITS-1:0] mag;
  logic                  neg;
  logic                  hex;
  logic                  accept;
  logic                  neg_q, neg_d;
  logic                  upper_q, upper_d;
  logic                  conv_done;
  logic [BCD_W-1:0]      digits;
  logic                  emit_active;
  emit_ctrl_t            emit_ctrl;

  // Decode the format and form the magnitude of the accepted word.
  assign op     = op_e'(op_i);
  assign word   = VALUE_BITS'(value_i);
  assign neg    = (op == OP_SDEC) && word[VALUE_BITS-1];
  assign mag    = neg ? (~word + VALUE_BITS'(1)) : word;
  assign hex    = (op == OP_HEXL) || (op == OP_HEXU);
  assign accept = start_i && (state_q == ST_IDLE);

  // Sequencer: convert, then hand the digits to the emitter.
  always_comb begin
    state_d   = state_q;
    neg_d     = neg_q;
    upper_d   = upper_q;
    emit_ctrl = '{load: 1'b0, neg: neg_q, upper: upper_q};
    unique case (state_q)
      ST_IDLE: begin
        if (start_i) begin
          neg_d   = neg;
          upper_d = (op == OP_HEXU);
          state_d = ST_CONV;
        end
      end
      ST_CONV: begin
        if (conv_done) begin
          emit_ctrl.load = 1'b1;
          state_d        = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (!emit_active) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      neg_q   <= 1'b0;
      upper_q <= 1'b0;
    end else begin
      state_q <= state_d;
      neg_q   <= neg_d;
      upper_q <= upper_d;
    end
  end

  assign busy_o = (state_q != ST_IDLE);

  i2a_bcd u_bcd (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (accept),
    .hex_i    (hex),
    .mag_i    (mag),
    .done_o   (conv_done),
    .digits_o (digits)
  );

  i2a_emit u_emit (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .ctrl_i      (emit_ctrl),
    .digits_i    (digits),
    .active_o    (emit_active),
    .valid_o     (valid_o),
    .char_code_o (char_code_o),
    .last_o      (last_o)
  );

  // A character word only appears while an item is in flight.
  assert property (@(posedge clk_i) disable iff (!rst_ni) valid_o |-> busy_o)
    else $error("character strobe outside a busy period");

  // An accepted item makes the block busy in the next cycle.
  assert property (@(posedge clk_i) disable iff (!rst_ni) accept |=> busy_o)
    else $error("accepted item did not raise busy");

  // Nothing follows the final character of a run.
  assert property (@(posedge clk_i) disable iff (!rst_ni) (valid_o && last_o) |=> !valid_o)
    else $error("character strobe after the final character");

  // Conversion completes only while the sequencer waits for it.
  assert property (@(posedge clk_i) disable iff (!rst_ni) conv_done |-> (state_q == ST_CONV))
    else $error("converter finished outside the conversion state");

endmodule

`default_nettype wire
